/* rtl/servo_pulse_slew_limiter_macros.svh */
// Assertion macros used by the servo pulse slew limiter RTL.
`ifndef SERVO_PULSE_SLEW_LIMITER_MACROS_SVH
`define SERVO_PULSE_SLEW_LIMITER_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define SPSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define SPSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spsl_pkg.sv */
// Package with constants and types for the servo pulse slew limiter.
package spsl_pkg;

    localparam int ADC_WIDTH_DEF = 12;
    localparam int PULSE_W       = 15;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 15;

    // Sample to pulse mapping: 450 + adc * 2100 / 3100.
    localparam int MAP_OFFSET = 450;
    localparam int MAP_MUL    = 2100;
    localparam int MAP_DIV    = 3100;

    localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

    // Reset values.
    localparam logic [7:0]         SLEW_STEP_RST    = 8'd10;
    localparam logic [7:0]         DEADBAND_RST     = 8'd5;
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST    = 15'd500;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST    = 15'd2500;
    localparam logic [2:0]         FILTER_SHIFT_RST = 3'd3;
    localparam logic [PULSE_W-1:0] HELD_PULSE_RST   = 15'd700;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLEW_STEP    = 3'd0,
        CFG_DEADBAND     = 3'd1,
        CFG_MIN_PULSE    = 3'd2,
        CFG_MAX_PULSE    = 3'd3,
        CFG_FILTER_SHIFT = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        MODE_TICK  = 1'b0,
        MODE_PRESS = 1'b1
    } t_mode;

endpackage

/* rtl/spsl_target_map.sv */
// Two-stage pipeline that maps an ADC sample to a target pulse width.
module spsl_target_map #(
    parameter int ADC_WIDTH = spsl_pkg::ADC_WIDTH_DEF,
    parameter int TW        = ADC_WIDTH + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_mode,
    input  logic [ADC_WIDTH-1:0] i_adc_sample,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_mode,
    output logic [TW-1:0]        o_target
);

    // The scaled sample adc * 2100 always fits in XW bits.
    localparam int XW = ADC_WIDTH + 12;
    localparam int PW = 2 * XW;
    // Reciprocal of the divisor; the estimate it gives is low by at most one.
    localparam logic [XW-1:0] RECIP = XW'((2 ** XW) / spsl_pkg::MAP_DIV);

    logic                 r_a_valid;
    logic                 r_a_mode;
    logic [XW-1:0]        r_a_x;
    logic [ADC_WIDTH-1:0] r_a_q;
    logic                 r_b_valid;
    logic                 r_b_mode;
    logic [TW-1:0]        r_b_target;

    logic                 w_b_free;
    logic [XW-1:0]        w_x;
    logic [PW-1:0]        w_prod;
    logic [XW-1:0]        w_rem;
    logic [ADC_WIDTH-1:0] w_q;
    logic [TW-1:0]        n_target;

    assign w_b_free = !r_b_valid || i_ready;
    assign o_ready  = !r_a_valid || w_b_free;

    assign w_x    = XW'(i_adc_sample) * XW'(spsl_pkg::MAP_MUL);
    assign w_prod = PW'(w_x) * PW'(RECIP);

    assign w_rem    = r_a_x - XW'(r_a_q) * XW'(spsl_pkg::MAP_DIV);
    assign w_q      = r_a_q + ADC_WIDTH'(w_rem >= XW'(spsl_pkg::MAP_DIV));
    assign n_target = TW'(spsl_pkg::MAP_OFFSET) + TW'(w_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_free) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_a_mode <= i_mode;
            r_a_x    <= w_x;
            r_a_q    <= w_prod[XW +: ADC_WIDTH];
        end
        if (w_b_free) begin
            r_b_mode   <= r_a_mode;
            r_b_target <= n_target;
        end
    end

    assign o_valid  = r_b_valid;
    assign o_mode   = r_b_mode;
    assign o_target = r_b_target;

endmodule

/* rtl/servo_pulse_slew_limiter.sv */
// Top level of the servo pulse slew limiter.
//
// Input channel (i_in_valid / o_in_ready): one beat is either a sample tick
// (i_mode low) carrying an ADC conversion, or a press of the enable toggle
// (i_mode high). Output channel (o_out_valid / i_out_ready): exactly one
// result beat per input beat, in order, giving the held pulse width, whether
// the compare value was written and whether the PWM output is enabled.
// Configuration channel (i_cfg_valid / o_cfg_ready): writes slew step,
// deadband, window limits and filter shift; it is always ready and should
// only be used while no beats are in flight.
// A result beat passes the two mapping registers and the result register
// after its input beat is accepted. Throughput is one beat per cycle while
// the receiver keeps up: two stages map the sample to a target pulse and
// the result stage updates the held pulse and holds all the feedback.
// If the receiver stalls, the result holds, the two mapping stages fill up,
// and then o_in_ready drops; no beat is lost or repeated.
// Reset is synchronous and active low. It empties the pipeline, restores
// the register defaults, sets the held pulse to 700 us with the output
// enabled, and arms the toggle so the first press enables the output.
`include "servo_pulse_slew_limiter_macros.svh"

module servo_pulse_slew_limiter #(
    parameter int ADC_WIDTH = spsl_pkg::ADC_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_mode,
    input  logic [ADC_WIDTH-1:0]            i_adc_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [spsl_pkg::PULSE_W-1:0]    o_pulse_width,
    output logic                            o_compare_written,
    output logic                            o_output_enabled,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [spsl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spsl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW = spsl_pkg::PULSE_W;
    // Target width fits the 450 us offset for samples of 8 bits or more.
    localparam int TW = ADC_WIDTH + 2;
    // Signed width of target minus held pulse.
    localparam int DW = ((TW > PW) ? TW : PW) + 1;

    // Configuration registers.
    logic [7:0]    r_slew_step;
    logic [7:0]    r_deadband;
    logic [PW-1:0] r_min_pulse;
    logic [PW-1:0] r_max_pulse;
    logic [2:0]    r_filter_shift;

    // Block state and result beat.
    logic [PW-1:0] r_held;
    logic          r_pwm_on;
    logic          r_next_press_enables;
    logic          r_out_valid;
    logic          r_out_written;

    logic          w_tgt_valid;
    logic          w_tgt_ready;
    logic          w_tgt_mode;
    logic [TW-1:0] w_tgt_target;
    logic          w_fire;

    logic signed [DW-1:0] w_diff;
    logic signed [DW-1:0] w_step;
    logic signed [DW-1:0] w_slew;
    logic [DW-1:0]        w_mag;
    logic                 w_in_window;
    logic                 w_move_ok;
    logic [PW:0]          w_up_sum;
    logic [PW-1:0]        w_up;
    logic [PW-1:0]        w_down;

    logic [PW-1:0] n_held;
    logic          n_pwm_on;
    logic          n_next_press_enables;
    logic          n_written;

    spsl_target_map #(
        .ADC_WIDTH (ADC_WIDTH),
        .TW        (TW)
    ) u_target_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_mode       (i_mode),
        .i_adc_sample (i_adc_sample),
        .o_valid      (w_tgt_valid),
        .i_ready      (w_tgt_ready),
        .o_mode       (w_tgt_mode),
        .o_target     (w_tgt_target)
    );

    // The result stage takes a new beat whenever its register is empty or
    // the current result is being taken.
    assign w_tgt_ready = !r_out_valid || i_out_ready;
    assign w_fire      = w_tgt_valid && w_tgt_ready;

    // Filter step: arithmetic shift of the error, which rounds toward minus
    // infinity for negative errors.
    assign w_diff      = $signed(DW'(w_tgt_target)) - $signed(DW'(r_held));
    assign w_step      = w_diff >>> r_filter_shift;
    assign w_mag       = w_step[DW-1] ? DW'(-w_step) : DW'(w_step);
    assign w_slew      = $signed(DW'(r_slew_step));
    assign w_in_window = (r_held >= r_min_pulse) && (r_held <= r_max_pulse);
    assign w_move_ok   = (w_mag > DW'(r_deadband)) && w_in_window;

    // Saturating moves by one slew step in either direction.
    assign w_up_sum = (PW + 1)'(r_held) + (PW + 1)'(r_slew_step);
    assign w_up     = w_up_sum[PW] ? spsl_pkg::PULSE_MAX : w_up_sum[PW-1:0];
    assign w_down   = (r_held < PW'(r_slew_step)) ? '0 : r_held - PW'(r_slew_step);

    always_comb begin
        n_held               = r_held;
        n_pwm_on             = r_pwm_on;
        n_next_press_enables = r_next_press_enables;
        n_written            = 1'b0;
        case (spsl_pkg::t_mode'(w_tgt_mode))
            spsl_pkg::MODE_PRESS: begin
                n_pwm_on             = r_next_press_enables;
                n_next_press_enables = !r_next_press_enables;
            end
            spsl_pkg::MODE_TICK: begin
                if (r_pwm_on && w_move_ok) begin
                    if (w_step > w_slew) begin
                        n_held    = w_up;
                        n_written = 1'b1;
                    end else if (w_step < -w_slew) begin
                        n_held    = w_down;
                        n_written = 1'b1;
                    end
                end
            end
            default: begin
                n_held = r_held;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held               <= spsl_pkg::HELD_PULSE_RST;
            r_pwm_on             <= 1'b1;
            r_next_press_enables <= 1'b1;
            r_out_valid          <= 1'b0;
            r_out_written        <= 1'b0;
        end else begin
            if (w_tgt_ready) begin
                r_out_valid <= w_tgt_valid;
            end
            if (w_fire) begin
                r_held               <= n_held;
                r_pwm_on             <= n_pwm_on;
                r_next_press_enables <= n_next_press_enables;
                r_out_written        <= n_written;
            end
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slew_step    <= spsl_pkg::SLEW_STEP_RST;
            r_deadband     <= spsl_pkg::DEADBAND_RST;
            r_min_pulse    <= spsl_pkg::MIN_PULSE_RST;
            r_max_pulse    <= spsl_pkg::MAX_PULSE_RST;
            r_filter_shift <= spsl_pkg::FILTER_SHIFT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (spsl_pkg::t_cfg_idx'(i_cfg_index))
                spsl_pkg::CFG_SLEW_STEP:    r_slew_step    <= i_cfg_data[7:0];
                spsl_pkg::CFG_DEADBAND:     r_deadband     <= i_cfg_data[7:0];
                spsl_pkg::CFG_MIN_PULSE:    r_min_pulse    <= i_cfg_data[PW-1:0];
                spsl_pkg::CFG_MAX_PULSE:    r_max_pulse    <= i_cfg_data[PW-1:0];
                spsl_pkg::CFG_FILTER_SHIFT: r_filter_shift <= i_cfg_data[2:0];
                default: begin
                    r_slew_step <= r_slew_step;
                end
            endcase
        end
    end

    // The held pulse and enable state change only when a result is loaded,
    // so they double as the result fields.
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_pulse_width     = r_held;
    assign o_compare_written = r_out_written;
    assign o_output_enabled  = r_pwm_on;

    // A compare write can only come from a tick taken while enabled.
    `SPSL_ASSERT_NOW(a_write_needs_enable, i_clk, i_rst_n,
        o_out_valid && o_compare_written, o_output_enabled,
        "compare written while output disabled")

    // Without a compare write the held pulse must not move.
    `SPSL_ASSERT_NEXT(a_hold_without_write, i_clk, i_rst_n,
        w_fire && !n_written, $stable(r_held),
        "held pulse changed without a compare write")

    // Every press flips the toggle phase.
    `SPSL_ASSERT_NEXT(a_press_toggles, i_clk, i_rst_n,
        w_fire && (w_tgt_mode == spsl_pkg::MODE_PRESS),
        (r_next_press_enables != $past(r_next_press_enables)),
        "press did not flip the toggle phase")

endmodule

/* test/servo_pulse_slew_limiter_checker.sv */
// Checker that predicts every result beat of the servo pulse slew limiter and compares it.
`timescale 1ns / 100ps

module servo_pulse_slew_limiter_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_mode,
    input  logic [spsl_pkg::ADC_WIDTH_DEF-1:0] i_adc_sample,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [spsl_pkg::PULSE_W-1:0]    i_pulse_width,
    input  logic                            i_compare_written,
    input  logic                            i_output_enabled,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [spsl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spsl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_moves
);

    localparam int PW = spsl_pkg::PULSE_W;
    localparam int AW = spsl_pkg::ADC_WIDTH_DEF;

    typedef struct packed {
        logic [PW-1:0] pulse_width;
        logic          compare_written;
        logic          output_enabled;
    } t_servo_beat;

    t_servo_beat awaited_q[$];

    // Own copy of the block state and its registers.
    int            held_us;
    bit            pwm_enabled;
    bit            press_enables;
    logic [7:0]    slew_us;
    logic [7:0]    deadband_us;
    logic [PW-1:0] window_lo;
    logic [PW-1:0] window_hi;
    logic [2:0]    smooth_shift;

    int mismatch_count = 0;
    int pending_count  = 0;
    int result_count   = 0;
    int move_count     = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;
    assign o_results    = result_count;
    assign o_moves      = move_count;

    // Applies one beat to the predicted state and returns the result it should produce.
    function automatic t_servo_beat advance_servo(input spsl_pkg::t_mode mode,
                                                  input logic [AW-1:0] adc);
        t_servo_beat beat;
        int          target;
        int          step;
        int          mag;
        int          slew;
        beat.compare_written = 1'b0;
        if (mode == spsl_pkg::MODE_PRESS) begin
            // The toggle alternates, starting with an enable.
            pwm_enabled   = press_enables;
            press_enables = !press_enables;
        end else if (pwm_enabled) begin
            target = spsl_pkg::MAP_OFFSET
                     + (int'(adc) * spsl_pkg::MAP_MUL) / spsl_pkg::MAP_DIV;
            step   = (target - held_us) >>> smooth_shift;
            mag    = (step < 0) ? -step : step;
            slew   = int'(slew_us);
            if (mag > int'(deadband_us) && held_us <= int'(window_hi)
                    && held_us >= int'(window_lo)) begin
                if (step > slew) begin
                    held_us = held_us + slew;
                    if (held_us > int'(spsl_pkg::PULSE_MAX))
                        held_us = int'(spsl_pkg::PULSE_MAX);
                    beat.compare_written = 1'b1;
                end else if (step < -slew) begin
                    held_us = held_us - slew;
                    if (held_us < 0) held_us = 0;
                    beat.compare_written = 1'b1;
                end
            end
        end
        beat.pulse_width    = held_us[PW-1:0];
        beat.output_enabled = pwm_enabled;
        return beat;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_servo_beat seen;
        t_servo_beat want;
        if (!i_rst_n) begin
            held_us       = int'(spsl_pkg::HELD_PULSE_RST);
            pwm_enabled   = 1'b1;
            press_enables = 1'b1;
            slew_us       = spsl_pkg::SLEW_STEP_RST;
            deadband_us   = spsl_pkg::DEADBAND_RST;
            window_lo     = spsl_pkg::MIN_PULSE_RST;
            window_hi     = spsl_pkg::MAX_PULSE_RST;
            smooth_shift  = spsl_pkg::FILTER_SHIFT_RST;
            awaited_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (spsl_pkg::t_cfg_idx'(i_cfg_index))
                    spsl_pkg::CFG_SLEW_STEP:    slew_us      = i_cfg_data[7:0];
                    spsl_pkg::CFG_DEADBAND:     deadband_us  = i_cfg_data[7:0];
                    spsl_pkg::CFG_MIN_PULSE:    window_lo    = i_cfg_data[PW-1:0];
                    spsl_pkg::CFG_MAX_PULSE:    window_hi    = i_cfg_data[PW-1:0];
                    spsl_pkg::CFG_FILTER_SHIFT: smooth_shift = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                seen.pulse_width     = i_pulse_width;
                seen.compare_written = i_compare_written;
                seen.output_enabled  = i_output_enabled;
                if (awaited_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: result beat %0d arrived with nothing awaited (pulse %0d)",
                                 $realtime, result_count, seen.pulse_width);
                    mismatch_count++;
                end else begin
                    want = awaited_q.pop_front();
                    if (want != seen) begin
                        if (mismatch_count < 10)
                            $display("%0t: beat %0d expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     $realtime, result_count,
                                     want.pulse_width, want.compare_written,
                                     want.output_enabled, seen.pulse_width,
                                     seen.compare_written, seen.output_enabled);
                        mismatch_count++;
                    end
                end
                if (seen.compare_written) move_count++;
                result_count++;
            end
            if (i_in_valid && i_in_ready)
                awaited_q.push_back(advance_servo(spsl_pkg::t_mode'(i_mode), i_adc_sample));
        end
        pending_count = awaited_q.size();
    end

endmodule

/* test/servo_pulse_slew_limiter_test.sv */
// Top of the servo pulse slew limiter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module servo_pulse_slew_limiter_test;

    localparam int AW = spsl_pkg::ADC_WIDTH_DEF;
    localparam int PW = spsl_pkg::PULSE_W;
    localparam int CW = spsl_pkg::CFG_DATA_W;

    // Cycles without any accepted beat on any channel before the run is given up.
    // The slowest legal stretch is the long receiver hold-off below plus the
    // pipeline drain, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int PHASE_COUNT    = 14;
    localparam int PHASE_BEATS    = 120;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic                             i_mode;
    logic [AW-1:0]                    i_adc_sample;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic [PW-1:0]                    o_pulse_width;
    logic                             o_compare_written;
    logic                             o_output_enabled;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [spsl_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [CW-1:0]                    i_cfg_data;

    int mismatches;
    int pending;
    int results;
    int moves;

    // Stimulus bookkeeping. The press count lets the sender guess whether the
    // output is enabled, so that most ticks land while the block is live.
    int presses        = 0;
    int settings_used  = 0;
    int quiet_cycles   = 0;
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_off_request = 1'b0;

    servo_pulse_slew_limiter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_adc_sample      (i_adc_sample),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_pulse_width     (o_pulse_width),
        .o_compare_written (o_compare_written),
        .o_output_enabled  (o_output_enabled),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    servo_pulse_slew_limiter_checker pulse_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_adc_sample      (i_adc_sample),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_pulse_width     (o_pulse_width),
        .i_compare_written (o_compare_written),
        .i_output_enabled  (o_output_enabled),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_results         (results),
        .o_moves           (moves)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: any accepted beat on any channel resets the count. Reaching the
    // limit means the block has hung, so the run ends there as a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results still awaited",
                     $realtime, WATCHDOG_LIMIT, pending);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver. For every result beat it draws a random stall, drops ready
    // during the stall and then waits with ready high until a beat is taken. A
    // request from the stimulus turns one stall into a long hold-off, during
    // which the sender keeps offering so the pipeline fills and backs up.
    initial begin : receiver
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = receiver_idles ? $urandom_range(0, 6) : 0;
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Offers one input beat. Called at a falling edge and returns at the falling
    // edge after the beat was taken, with valid still high. A zero gap keeps
    // valid high straight into the next beat, so valid is assigned once per step.
    task automatic offer_beat(input spsl_pkg::t_mode mode, input logic [AW-1:0] adc);
        int gap;
        gap = sender_idles ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_adc_sample <= adc;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (mode == spsl_pkg::MODE_PRESS) presses++;
    endtask

    // Stops offering and waits until every awaited result has come back, so
    // the block is idle and its registers may be rewritten.
    task automatic wait_until_drained();
        i_in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    // One configuration beat. Like offer_beat, valid is left high on return so
    // that back-to-back writes never lower and raise it in the same step.
    task automatic write_reg(input spsl_pkg::t_cfg_idx idx, input logic [CW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [7:0] slew, input logic [7:0] dead,
                                  input logic [PW-1:0] lo,
                                  input logic [PW-1:0] hi,
                                  input logic [2:0] shift);
        write_reg(spsl_pkg::CFG_SLEW_STEP, CW'(slew));
        write_reg(spsl_pkg::CFG_DEADBAND, CW'(dead));
        write_reg(spsl_pkg::CFG_MIN_PULSE, CW'(lo));
        write_reg(spsl_pkg::CFG_MAX_PULSE, CW'(hi));
        write_reg(spsl_pkg::CFG_FILTER_SHIFT, CW'(shift));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random beats for one register setting. The knob models a potentiometer
    // that mostly rests and jitters a little, so the held pulse settles and the
    // deadband gets exercised; the rest are full-range samples, the two rail
    // values and presses. While the output is believed disabled, a press is
    // likely so that most ticks do real work.
    task automatic run_random_phase(input int beats, input bit with_hold);
        int  knob;
        int  pick;
        int  value;
        bit  output_on;
        knob = $urandom_range(0, 4095);
        for (int i = 0; i < beats; i++) begin
            if (with_hold && i == beats / 4) hold_off_request = 1'b1;
            output_on = (presses == 0) || (presses % 2 == 1);
            if ($urandom_range(0, 15) == 0) knob = $urandom_range(0, 4095);
            if ((!output_on && $urandom_range(0, 1) == 1) || $urandom_range(0, 11) == 0) begin
                offer_beat(spsl_pkg::MODE_PRESS, AW'($urandom_range(0, 4095)));
            end else begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    value = ($urandom_range(0, 1) == 1) ? 4095 : 0;
                end else if (pick <= 4) begin
                    value = $urandom_range(0, 4095);
                end else begin
                    value = knob + $urandom_range(0, 16) - 8;
                    if (value < 0) value = 0;
                    if (value > 4095) value = 4095;
                end
                offer_beat(spsl_pkg::MODE_TICK, AW'(value));
            end
        end
    endtask

    initial begin : stimulus
        int r_slew;
        int r_dead;
        int r_lo;
        int r_hi;
        int r_shift;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_mode       = spsl_pkg::MODE_TICK;
        i_adc_sample = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = spsl_pkg::CFG_SLEW_STEP;
        i_cfg_data   = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with the reset register values. A zero sample pulls the
        // held pulse down (negative filter step), full scale pushes it up, and
        // alternating bit patterns follow.
        offer_beat(spsl_pkg::MODE_TICK, 12'd0);
        offer_beat(spsl_pkg::MODE_TICK, 12'd4095);
        offer_beat(spsl_pkg::MODE_TICK, 12'd4095);
        offer_beat(spsl_pkg::MODE_TICK, 12'hAAA);
        offer_beat(spsl_pkg::MODE_TICK, 12'h555);
        // The first press enables an output that is already on.
        offer_beat(spsl_pkg::MODE_PRESS, 12'd0);
        offer_beat(spsl_pkg::MODE_TICK, 12'd4095);
        // The second press disables; ticks then change nothing.
        offer_beat(spsl_pkg::MODE_PRESS, 12'hFFF);
        offer_beat(spsl_pkg::MODE_TICK, 12'd4095);
        offer_beat(spsl_pkg::MODE_TICK, 12'd0);
        offer_beat(spsl_pkg::MODE_PRESS, 12'd0);
        // A sample whose target sits close to the held pulse leaves it unchanged.
        offer_beat(spsl_pkg::MODE_TICK, 12'd369);
        offer_beat(spsl_pkg::MODE_TICK, 12'd369);
        offer_beat(spsl_pkg::MODE_TICK, 12'd1);
        offer_beat(spsl_pkg::MODE_TICK, 12'd2048);
        wait_until_drained();

        // Register settings: zero slew (a write with no movement), the widest
        // deadband with the deepest filter, an inverted window, a narrow window
        // that freezes the held pulse once it leaves, full slew with no
        // filtering, random settings, and the reset values to finish.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: apply_settings(8'd0, 8'd0, 15'd0, 15'd20000, 3'd0);
                1: apply_settings(8'd255, 8'd255, 15'd0, 15'd20000, 3'd7);
                2: apply_settings(8'd1, 8'd0, 15'd20000, 15'd0, 3'd2);
                3: apply_settings(8'd10, 8'd5, 15'd1500, 15'd1600, 3'd3);
                4: apply_settings(8'd255, 8'd0, 15'd0, 15'd20000, 3'd0);
                PHASE_COUNT - 1: apply_settings(spsl_pkg::SLEW_STEP_RST,
                                                spsl_pkg::DEADBAND_RST,
                                                spsl_pkg::MIN_PULSE_RST,
                                                spsl_pkg::MAX_PULSE_RST,
                                                spsl_pkg::FILTER_SHIFT_RST);
                default: begin
                    r_slew  = $urandom_range(0, 255);
                    r_dead  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, 20);
                    if ($urandom_range(0, 3) == 0) begin
                        r_lo = $urandom_range(0, 20000);
                        r_hi = $urandom_range(0, 20000);
                    end else begin
                        r_lo = $urandom_range(0, 600);
                        r_hi = $urandom_range(3300, 20000);
                    end
                    r_shift = $urandom_range(0, 7);
                    apply_settings(8'(r_slew), 8'(r_dead), PW'(r_lo), PW'(r_hi),
                                   3'(r_shift));
                end
            endcase
            // One phase runs flat out on both sides; the others idle at random.
            sender_idles   = (p == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
            receiver_idles = (p == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
            run_random_phase(PHASE_BEATS, p == 5);
            wait_until_drained();
        end

        // Let the pipeline run on in case a stray beat appears.
        repeat (8) @(negedge i_clk);
        $display("covered %0d beats over %0d register settings after the reset defaults,",
                 results, settings_used);
        $display("with %0d toggle presses, %0d compare writes and one long receiver hold-off",
                 presses, moves);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
